[rtl/sceq_pkg.sv]
// Shared types and constants for the scancode event queue.
// Used by every module in rtl/ except sceq_ram; depends on nothing.
package sceq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int LEVEL_W     = 5;
    localparam int CODE_W      = 8;

    localparam logic [CODE_W-1:0] PREFIX_BYTE = 8'hE0;
    localparam logic [CODE_W-1:0] HIGH_BIT    = 8'h80;
    localparam logic [CODE_W-1:0] LOW_SEVEN   = 8'h7F;

    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef struct packed {
        logic              release_flag;
        logic [CODE_W-1:0] code;
    } event_t;

    localparam int EVENT_W = $bits(event_t);

    typedef struct packed {
        logic             pop_hit;
        logic             drop;
        logic [CNT_W-1:0] count_next;
    } fifo_stat_t;

endpackage

[rtl/sceq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Self-contained; no package dependency.
module sceq_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/sceq_decode.sv]
// Scan byte decoder: prefix flag register and key event formation.
// Depends on sceq_pkg.
module sceq_decode
    import sceq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [CODE_W-1:0] scan_byte,
    output event_t            ev,
    output logic              ev_make
);

    logic prefix_reg;
    logic prefix_next;
    logic is_prefix;

    assign is_prefix = (scan_byte == PREFIX_BYTE);
    assign ev_make   = !is_prefix;

    always_comb
    begin
        ev.release_flag = scan_byte[CODE_W-1];
        if (scan_byte[CODE_W-1])
        begin
            ev.code = prefix_reg ? scan_byte : (scan_byte & LOW_SEVEN);
        end
        else
        begin
            ev.code = prefix_reg ? (scan_byte | HIGH_BIT) : scan_byte;
        end
        prefix_next = take ? is_prefix : prefix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= 1'b0;
        end
        else
        begin
            prefix_reg <= prefix_next;
        end
    end

endmodule

[rtl/sceq_fifo.sv]
// Event FIFO: pointers, fill count and the event RAM.
// Depends on sceq_pkg and sceq_ram.
module sceq_fifo
    import sceq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       pop_req,
    input  event_t     wdata,
    output fifo_stat_t stat,
    output event_t     rdata
);

    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic             full;
    logic             empty;
    logic             do_push;
    logic [EVENT_W-1:0] ram_rdata;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;

    always_comb
    begin
        stat.pop_hit    = pop_req && !empty;
        stat.drop       = push && full;
        stat.count_next = count_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        if (stat.pop_hit)
        begin
            stat.count_next = count_reg - 1'b1;
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        else if (do_push)
        begin
            stat.count_next = count_reg + 1'b1;
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= stat.count_next;
        end
    end

    sceq_ram #(
        .WIDTH (EVENT_W),
        .DEPTH (QUEUE_DEPTH),
        .ADDR_W(PTR_W)
    ) u_ram (
        .clk  (clk),
        .we   (do_push),
        .waddr(wr_ptr_reg),
        .wdata(wdata),
        .re   (stat.pop_hit),
        .raddr(rd_ptr_reg),
        .rdata(ram_rdata)
    );

    assign rdata = event_t'(ram_rdata);

endmodule

[rtl/scancode_event_queue.sv]
// Top level of the scancode event queue: handshake, result register, assertions.
// Depends on sceq_pkg, sceq_decode and sceq_fifo.
//
// Input channel (in_valid/in_stall): each transaction carries op and scan_byte.
// op = OP_SCAN delivers a keyboard scan byte; op = OP_POP pops the oldest event.
// Output channel (out_valid/out_stall): exactly one result transaction per input
// transaction, in order: event_valid/key_code/is_release for a successful pop,
// dropped when a decoded event found the queue full, not_empty and fill_level
// after the transaction.
// The result is registered at the acceptance edge and presented in the cycle after the input is accepted.
// Throughput: one transaction per cycle; queue state and the event RAM are
// updated at the acceptance edge and the RAM read data lands with the result.
// When out_stall holds a pending result, in_stall rises in the same cycle and
// the result, the queue and the RAM read data all hold.
// Reset (rst_n low, asynchronous) empties the queue, clears the prefix flag and
// drops any pending result. RAM contents are not cleared.
module scancode_event_queue
    import sceq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic [CODE_W-1:0]  scan_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               event_valid,
    output logic [CODE_W-1:0]  key_code,
    output logic               is_release,
    output logic               not_empty,
    output logic               dropped,
    output logic [LEVEL_W-1:0] fill_level
);

    logic               advance;
    logic               accept;
    logic               scan_take;
    logic               pop_req;
    event_t             dec_ev;
    logic               dec_make;
    fifo_stat_t         stat;
    event_t             fifo_rdata;

    logic               out_valid_reg;
    logic               ev_valid_reg;
    logic               dropped_reg;
    logic               not_empty_reg;
    logic [LEVEL_W-1:0] fill_level_reg;

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = !advance;
    assign accept    = in_valid && advance;
    assign scan_take = accept && (op == OP_SCAN);
    assign pop_req   = accept && (op == OP_POP);

    sceq_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (scan_take),
        .scan_byte(scan_byte),
        .ev       (dec_ev),
        .ev_make  (dec_make)
    );

    sceq_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (scan_take && dec_make),
        .pop_req(pop_req),
        .wdata  (dec_ev),
        .stat   (stat),
        .rdata  (fifo_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            ev_valid_reg   <= 1'b0;
            dropped_reg    <= 1'b0;
            not_empty_reg  <= 1'b0;
            fill_level_reg <= '0;
        end
        else if (advance)
        begin
            out_valid_reg  <= in_valid;
            ev_valid_reg   <= stat.pop_hit;
            dropped_reg    <= stat.drop;
            not_empty_reg  <= (stat.count_next != '0);
            fill_level_reg <= LEVEL_W'(stat.count_next);
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_valid = ev_valid_reg;
    assign key_code    = ev_valid_reg ? fifo_rdata.code : '0;
    assign is_release  = ev_valid_reg ? fifo_rdata.release_flag : 1'b0;
    assign not_empty   = not_empty_reg;
    assign dropped     = dropped_reg;
    assign fill_level  = fill_level_reg;

    // a pop result never reports a drop
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_valid) |-> !dropped)
        else $error("pop result flagged as dropped");

    // a drop only happens with the queue full
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && dropped) |-> (fill_level == LEVEL_W'(QUEUE_DEPTH)))
        else $error("drop reported with queue not full");

    // every accepted transaction yields a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("accepted transaction produced no result");

    // a successful pop needs a nonempty queue beforehand
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && op == OP_POP && !not_empty && out_valid) |=> !event_valid)
        else $error("pop returned an event from an empty queue");

endmodule

[bench/scancode_event_queue_tb.sv]
`timescale 1ns / 1ps
// Testbench for scancode_event_queue: directed and random scan-byte/pop transactions,
// each result checked against an in-bench key decoder and event queue.
// Depends on sceq_pkg and the RTL top level scancode_event_queue.
module scancode_event_queue_tb
    import sceq_pkg::*;
;

    localparam int RANDOM_ITEMS = 1400;
    localparam int IDLE_PCT     = 7;

    typedef struct packed {
        logic               event_valid;
        logic [CODE_W-1:0]  key_code;
        logic               is_release;
        logic               not_empty;
        logic               dropped;
        logic [LEVEL_W-1:0] fill_level;
    } key_result_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic               op        = OP_SCAN;
    logic [CODE_W-1:0]  scan_byte = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               event_valid;
    logic [CODE_W-1:0]  key_code;
    logic               is_release;
    logic               not_empty;
    logic               dropped;
    logic [LEVEL_W-1:0] fill_level;

    bit          quiet = 1'b0;
    bit          prefix_armed = 1'b0;
    event_t      queued_events[$];
    key_result_t expected_results[$];
    int unsigned mismatches     = 0;
    int unsigned results_seen   = 0;
    int unsigned keys_sent      = 0;
    int unsigned prefixes_sent  = 0;
    int unsigned pops_sent      = 0;
    int unsigned events_popped  = 0;
    int unsigned events_dropped = 0;

    scancode_event_queue u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .scan_byte   (scan_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_valid (event_valid),
        .key_code    (key_code),
        .is_release  (is_release),
        .not_empty   (not_empty),
        .dropped     (dropped),
        .fill_level  (fill_level)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic key_result_t decode_and_queue(input logic item_op,
                                                     input logic [CODE_W-1:0] item_byte);
        key_result_t r;
        event_t      ev;
        r = '0;
        if (item_op == OP_POP)
        begin
            pops_sent++;
            if (queued_events.size() != 0)
            begin
                ev = queued_events.pop_front();
                r.event_valid = 1'b1;
                r.key_code    = ev.code;
                r.is_release  = ev.release_flag;
                events_popped++;
            end
        end
        else if (item_byte == PREFIX_BYTE)
        begin
            prefix_armed = 1'b1;
            prefixes_sent++;
        end
        else
        begin
            keys_sent++;
            ev.release_flag = ((item_byte & HIGH_BIT) != '0);
            if (ev.release_flag)
                ev.code = prefix_armed ? item_byte : (item_byte & LOW_SEVEN);
            else
                ev.code = prefix_armed ? (item_byte | HIGH_BIT) : item_byte;
            if (queued_events.size() < QUEUE_DEPTH)
                queued_events.push_back(ev);
            else
            begin
                r.dropped = 1'b1;
                events_dropped++;
            end
            prefix_armed = 1'b0;
        end
        r.not_empty  = (queued_events.size() != 0);
        r.fill_level = LEVEL_W'(queued_events.size());
        return r;
    endfunction

    function automatic logic [CODE_W-1:0] random_key_byte();
        logic [CODE_W-1:0] b;
        do
            b = CODE_W'($urandom_range(255));
        while (b == PREFIX_BYTE);
        return b;
    endfunction

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
                 $time, field, got, want);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input logic item_op, input logic [CODE_W-1:0] item_byte);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        op        <= item_op;
        scan_byte <= item_byte;
        do
            @(posedge clk);
        while (in_stall);
        expected_results.push_back(decode_and_queue(item_op, item_byte));
        @(negedge clk);
    endtask

    always @(negedge clk)
        out_stall <= rst_n && !quiet && ($urandom_range(99) < IDLE_PCT);

    always @(posedge clk)
    begin : result_check
        key_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_results.size() == 0)
                report_mismatch("unexpected result transaction", fill_level, 0);
            else
            begin
                want = expected_results.pop_front();
                if (event_valid !== want.event_valid)
                    report_mismatch("event_valid", event_valid, want.event_valid);
                if (key_code !== want.key_code)
                    report_mismatch("key_code", key_code, want.key_code);
                if (is_release !== want.is_release)
                    report_mismatch("is_release", is_release, want.is_release);
                if (not_empty !== want.not_empty)
                    report_mismatch("not_empty", not_empty, want.not_empty);
                if (dropped !== want.dropped)
                    report_mismatch("dropped", dropped, want.dropped);
                if (fill_level !== want.fill_level)
                    report_mismatch("fill_level", fill_level, want.fill_level);
            end
        end
    end

    task automatic test_pop_empty();
        send_item(OP_POP, 8'hA5);
        send_item(OP_POP, 8'h5A);
    endtask

    task automatic test_decode_extremes();
        send_item(OP_SCAN, 8'h00);
        send_item(OP_SCAN, 8'h7F);
        send_item(OP_SCAN, 8'h80);
        send_item(OP_SCAN, 8'hFF);
        send_item(OP_SCAN, 8'h01);
        send_item(OP_SCAN, 8'h81);
    endtask

    task automatic test_prefix_cases();
        send_item(OP_SCAN, PREFIX_BYTE);
        send_item(OP_SCAN, 8'h00);
        send_item(OP_SCAN, PREFIX_BYTE);
        send_item(OP_SCAN, 8'h7F);
        send_item(OP_SCAN, PREFIX_BYTE);
        send_item(OP_SCAN, 8'h80);
        send_item(OP_SCAN, PREFIX_BYTE);
        send_item(OP_SCAN, 8'hFF);
        // repeated prefix, then a pop between prefix and key
        send_item(OP_SCAN, PREFIX_BYTE);
        send_item(OP_SCAN, PREFIX_BYTE);
        send_item(OP_SCAN, 8'h2A);
        send_item(OP_SCAN, PREFIX_BYTE);
        send_item(OP_POP, 8'hFF);
        send_item(OP_SCAN, 8'hAA);
    endtask

    task automatic test_queue_overflow();
        while (queued_events.size() < QUEUE_DEPTH)
            send_item(OP_SCAN, random_key_byte());
        send_item(OP_SCAN, PREFIX_BYTE);
        send_item(OP_SCAN, 8'h48);
        send_item(OP_SCAN, 8'hC8);
        send_item(OP_POP, 8'h00);
        send_item(OP_SCAN, 8'h1C);
    endtask

    task automatic test_random_traffic(input int n);
        int i;
        int roll;
        int scan_bias;
        scan_bias = 50;
        for (i = 0; i < n; i++)
        begin
            if (i % 100 == 0)
            begin
                case ($urandom_range(2))
                    0:       scan_bias = 30;
                    1:       scan_bias = 55;
                    default: scan_bias = 85;
                endcase
            end
            quiet = (i >= n / 3) && (i < n / 2);
            roll = $urandom_range(99);
            if (roll < 8)
                send_item(logic'($urandom_range(1)), CODE_W'($urandom_range(255)));
            else if (roll < scan_bias)
            begin
                if ($urandom_range(3) == 0)
                begin
                    send_item(OP_SCAN, PREFIX_BYTE);
                    if ($urandom_range(7) == 0)
                        send_item(OP_SCAN, PREFIX_BYTE);
                end
                send_item(OP_SCAN, random_key_byte());
            end
            else
                send_item(OP_POP, CODE_W'($urandom_range(255)));
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_pop_empty();
        test_decode_extremes();
        test_prefix_cases();
        test_queue_overflow();
        test_random_traffic(RANDOM_ITEMS);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        $display("Covered %0d key bytes, %0d prefixes, %0d pops (%0d returned an event).",
                 keys_sent, prefixes_sent, pops_sent, events_popped);
        $display("%0d events dropped on a full queue; %0d results checked, %0d mismatches.",
                 events_dropped, results_seen, mismatches);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timeout with %0d results outstanding", expected_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
